// ===== rtl/caldc_pkg.sv =====
// caldc_pkg: field widths, codes, date types and calendar helper functions
// for the calendar date counter; no dependencies
package caldc_pkg;

  localparam int FUNC_W  = 3;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int YEAR_W  = 14;
  localparam int ORDER_W = 2;
  localparam int CENT_W  = 8;

  // divide by 100 as multiply by reciprocal, exact for every 14-bit year
  localparam int DIV100_MUL_W = 13;
  localparam int DIV100_SHIFT = 19;
  localparam int DIV100_PROD_W = YEAR_W + DIV100_MUL_W;
  localparam logic [DIV100_PROD_W-1:0] DIV100_MUL = DIV100_PROD_W'(5243);
  localparam logic [YEAR_W-1:0] HUNDRED = YEAR_W'(100);

  localparam logic [YEAR_W-1:0]  YEAR_MIN   = YEAR_W'(1);
  localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR  = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN  = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP  = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV  = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST  = DAY_W'(1);
  localparam logic [DAY_W-1:0]   DAYS_28    = DAY_W'(28);
  localparam logic [DAY_W-1:0]   DAYS_29    = DAY_W'(29);
  localparam logic [DAY_W-1:0]   DAYS_30    = DAY_W'(30);
  localparam logic [DAY_W-1:0]   DAYS_31    = DAY_W'(31);
  localparam logic [YEAR_W-1:0]  RESET_YEAR = YEAR_W'(2000);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD = 3'd0,
    FUNC_NEXT = 3'd1,
    FUNC_PREV = 3'd2,
    FUNC_CMP  = 3'd3,
    FUNC_CENT = 3'd4
  } func_t;

  typedef enum logic [ORDER_W-1:0] {
    ORD_LESS    = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_GREATER = 2'd2
  } order_t;

  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [YEAR_W-1:0]  year;
  } date_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    date_t             date;
  } req_t;

  typedef struct packed {
    date_t              date;
    logic               ok;
    logic [ORDER_W-1:0] order;
  } rsp_t;

  function automatic logic [CENT_W-1:0] div100(input logic [YEAR_W-1:0] y);
    logic [DIV100_PROD_W-1:0] prod;
    prod = DIV100_PROD_W'(y) * DIV100_MUL;
    return prod[DIV100_SHIFT +: CENT_W];
  endfunction

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [CENT_W-1:0] q;
    logic [YEAR_W-1:0] rem;
    q   = div100(y);
    rem = y - YEAR_W'(q) * HUNDRED;
    // on a century year the quotient decides the 400 rule
    if (rem == '0) return (q[1:0] == 2'b00);
    return (y[1:0] == 2'b00);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic [YEAR_W-1:0] y);
    logic [DAY_W-1:0] len;
    len = DAYS_31;
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = DAYS_30;
    end else if (m == MONTH_FEB) begin
      len = is_leap(y) ? DAYS_29 : DAYS_28;
    end
    return len;
  endfunction

  // century ordering key: year 0 lowest, years ending in 00 close their century
  function automatic logic [CENT_W-1:0] cent_key(input logic [YEAR_W-1:0] y);
    if (y == '0) return '0;
    return div100(y - YEAR_W'(1)) + CENT_W'(1);
  endfunction

  function automatic logic [ORDER_W-1:0] cmp3(input logic [YEAR_W-1:0] a,
                                              input logic [YEAR_W-1:0] b);
    if (a < b) return ORD_LESS;
    if (a > b) return ORD_GREATER;
    return ORD_EQUAL;
  endfunction

endpackage

// ===== rtl/caldc_if.sv =====
// caldc_req_if / caldc_rsp_if: valid-ready channels for requests and results
// depends on caldc_pkg for field widths
interface caldc_req_if;
  logic                            valid;
  logic                            ready;
  logic [caldc_pkg::FUNC_W-1:0]    func;
  logic [caldc_pkg::MONTH_W-1:0]   month_in;
  logic [caldc_pkg::DAY_W-1:0]     day_in;
  logic [caldc_pkg::YEAR_W-1:0]    year_in;

  modport source (output valid, func, month_in, day_in, year_in, input ready);
  modport sink   (input valid, func, month_in, day_in, year_in, output ready);
endinterface

interface caldc_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [caldc_pkg::MONTH_W-1:0]   cur_month;
  logic [caldc_pkg::DAY_W-1:0]     cur_day;
  logic [caldc_pkg::YEAR_W-1:0]    cur_year;
  logic                            ok;
  logic [caldc_pkg::ORDER_W-1:0]   order;

  modport source (output valid, cur_month, cur_day, cur_year, ok, order, input ready);
  modport sink   (input valid, cur_month, cur_day, cur_year, ok, order, output ready);
endinterface

// ===== rtl/caldc_update.sv =====
// caldc_update: next stored date, status and compare result for one request
// depends on caldc_pkg
module caldc_update (
  input  caldc_pkg::date_t cur,
  input  caldc_pkg::req_t  req,
  output caldc_pkg::date_t date_nxt,
  output caldc_pkg::rsp_t  rsp
);
  import caldc_pkg::*;

  logic             load_valid;
  logic [DAY_W-1:0] cur_len;
  logic [DAY_W-1:0] prev_len;
  logic [ORDER_W-1:0] ord;
  logic             ok;

  assign load_valid = (req.date.year >= YEAR_MIN) && (req.date.year <= YEAR_MAX) &&
                      (req.date.month >= MONTH_JAN) && (req.date.month <= MONTH_DEC) &&
                      (req.date.day >= DAY_FIRST) &&
                      (req.date.day <= month_len(req.date.month, req.date.year));

  assign cur_len  = month_len(cur.month, cur.year);
  assign prev_len = month_len(cur.month - MONTH_W'(1), cur.year);

  always_comb begin
    date_nxt = cur;
    ok       = 1'b1;
    ord      = ORD_EQUAL;
    unique case (req.func)
      FUNC_LOAD: begin
        if (load_valid) date_nxt = req.date;
        else ok = 1'b0;
      end
      FUNC_NEXT: begin
        priority if (cur.day < cur_len) begin
          date_nxt.day = cur.day + DAY_W'(1);
        end else if (cur.month < MONTH_DEC) begin
          date_nxt.month = cur.month + MONTH_W'(1);
          date_nxt.day   = DAY_FIRST;
        end else if (cur.year < YEAR_MAX) begin
          date_nxt.year  = cur.year + YEAR_W'(1);
          date_nxt.month = MONTH_JAN;
          date_nxt.day   = DAY_FIRST;
        end else begin
          ok = 1'b0;
        end
      end
      FUNC_PREV: begin
        priority if (cur.day > DAY_FIRST) begin
          date_nxt.day = cur.day - DAY_W'(1);
        end else if (cur.month > MONTH_JAN) begin
          date_nxt.month = cur.month - MONTH_W'(1);
          date_nxt.day   = prev_len;
        end else if (cur.year > YEAR_MIN) begin
          date_nxt.year  = cur.year - YEAR_W'(1);
          date_nxt.month = MONTH_DEC;
          date_nxt.day   = DAYS_31;
        end else begin
          ok = 1'b0;
        end
      end
      FUNC_CMP: begin
        ord = cmp3(cur.year, req.date.year);
        if (ord == ORD_EQUAL) ord = cmp3(YEAR_W'(cur.month), YEAR_W'(req.date.month));
        if (ord == ORD_EQUAL) ord = cmp3(YEAR_W'(cur.day), YEAR_W'(req.date.day));
      end
      FUNC_CENT: begin
        ord = cmp3(YEAR_W'(cent_key(cur.year)), YEAR_W'(cent_key(req.date.year)));
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign rsp.date  = date_nxt;
  assign rsp.ok    = ok;
  assign rsp.order = ord;

endmodule

// ===== rtl/calendar_date_counter_unit.sv =====
// calendar_date_counter_unit: top level of the Gregorian date counter
// depends on caldc_pkg, caldc_req_if, caldc_rsp_if and caldc_update
//
// Holds one calendar date, 1/1/2000 after reset. Each request on the in_req
// channel carries an operation (load, next day, previous day, date compare,
// century compare) and a given date; every request yields exactly one result
// on out_rsp with the stored date after the request, an ok flag and the
// compare order.
// A request accepted on in_req is captured in an input register; the update
// logic then writes the stored date and the result register together once the
// result register is empty or being taken, and out_rsp.valid rises with the
// registered result, which the receiver can then take.
// Throughput is one request per cycle while the receiver does not stall: the
// stored date register is the only loop, and it closes through the update logic.
// When the receiver stalls, the result register holds its result and the
// input register still takes one more request; in_req.ready drops only once
// both are full. Synchronous active-low reset empties both registers and
// restores 1/1/2000.
module calendar_date_counter_unit (
  input logic        clk,
  input logic        rst_n,
  caldc_req_if.sink  in_req,
  caldc_rsp_if.source out_rsp
);
  import caldc_pkg::*;

  logic  in_v_r;
  logic  out_v_r;
  req_t  req_r;
  rsp_t  rsp_r;
  date_t date_r;
  date_t date_nxt;
  rsp_t  rsp_nxt;
  logic  fire;
  logic  in_ready;

  assign fire     = in_v_r && (!out_v_r || out_rsp.ready);
  assign in_ready = !in_v_r || fire;

  caldc_update u_update (
    .cur      (date_r),
    .req      (req_r),
    .date_nxt (date_nxt),
    .rsp      (rsp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      date_r.month <= MONTH_JAN;
      date_r.day   <= DAY_FIRST;
      date_r.year  <= RESET_YEAR;
    end else begin
      if (in_ready) in_v_r <= in_req.valid;
      if (fire) begin
        out_v_r <= 1'b1;
        date_r  <= date_nxt;
      end else if (out_rsp.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_req.valid && in_ready) begin
      req_r.func       <= in_req.func;
      req_r.date.month <= in_req.month_in;
      req_r.date.day   <= in_req.day_in;
      req_r.date.year  <= in_req.year_in;
    end
    if (fire) rsp_r <= rsp_nxt;
  end

  assign in_req.ready      = in_ready;
  assign out_rsp.valid     = out_v_r;
  assign out_rsp.cur_month = rsp_r.date.month;
  assign out_rsp.cur_day   = rsp_r.date.day;
  assign out_rsp.cur_year  = rsp_r.date.year;
  assign out_rsp.ok        = rsp_r.ok;
  assign out_rsp.order     = rsp_r.order;

endmodule

// ===== bench/calendar_date_counter_unit_tb.sv =====
`timescale 1ns / 100ps
// calendar_date_counter_unit_tb: self-checking bench for the date counter, with directed
// and random requests under several valid/ready idle mixes
// depends on caldc_pkg, caldc_req_if, caldc_rsp_if and calendar_date_counter_unit
module calendar_date_counter_unit_tb;
  import caldc_pkg::*;

  localparam int RANDOM_PER_PHASE = 306;
  localparam int NUM_PHASES = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 40;
  localparam logic [FUNC_W-1:0] FUNC_UNDEF_LO = FUNC_W'(5);
  localparam logic [FUNC_W-1:0] FUNC_UNDEF_HI = '1;

  localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 82, 0, 25};
  localparam int STALL_PCT [NUM_PHASES] = '{0, 0, 82, 25};

  logic clk = 1'b0;
  logic rst_n;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int unsigned sent = 0;

  caldc_req_if in_req();
  caldc_rsp_if out_rsp();

  calendar_date_counter_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(in_req),
    .out_rsp(out_rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // calendar rules

  function automatic bit leap_year(input logic [YEAR_W-1:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic [YEAR_W-1:0] y);
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) return DAYS_30;
    if (m == MONTH_FEB) return leap_year(y) ? DAYS_29 : DAYS_28;
    return DAYS_31;
  endfunction

  function automatic bit date_valid(input date_t dt);
    if (dt.year < YEAR_MIN || dt.year > YEAR_MAX) return 1'b0;
    if (dt.month < MONTH_JAN || dt.month > MONTH_DEC) return 1'b0;
    if (dt.day < DAY_FIRST || dt.day > days_in_month(dt.month, dt.year)) return 1'b0;
    return 1'b1;
  endfunction

  // years ending in 00 close the century before their quotient
  function automatic int century_of(input logic [YEAR_W-1:0] y);
    int c;
    c = int'(y) / 100;
    if (y % 100 == 0) c = c - 1;
    return c;
  endfunction

  function automatic logic [ORDER_W-1:0] order_of(input int a, input int b);
    if (a < b) return ORD_LESS;
    if (a > b) return ORD_GREATER;
    return ORD_EQUAL;
  endfunction

  class date_scoreboard;
    date_t stored;
    rsp_t pending[$];
    int unsigned errors = 0;
    int unsigned checked = 0;
    int unsigned refused = 0;
    int unsigned compares = 0;

    function new();
      stored.month = MONTH_JAN;
      stored.day = DAY_FIRST;
      stored.year = RESET_YEAR;
    endfunction

    function void note_request(input req_t r);
      rsp_t res;
      res.ok = 1'b1;
      res.order = ORD_EQUAL;
      case (r.func)
        FUNC_LOAD: begin
          if (date_valid(r.date)) stored = r.date;
          else res.ok = 1'b0;
        end
        FUNC_NEXT: begin
          if (stored.day < days_in_month(stored.month, stored.year)) begin
            stored.day = stored.day + 1'b1;
          end else if (stored.month < MONTH_DEC) begin
            stored.month = stored.month + 1'b1;
            stored.day = DAY_FIRST;
          end else if (stored.year < YEAR_MAX) begin
            stored.year = stored.year + 1'b1;
            stored.month = MONTH_JAN;
            stored.day = DAY_FIRST;
          end else begin
            res.ok = 1'b0;
          end
        end
        FUNC_PREV: begin
          if (stored.day > DAY_FIRST) begin
            stored.day = stored.day - 1'b1;
          end else if (stored.month > MONTH_JAN) begin
            stored.month = stored.month - 1'b1;
            stored.day = days_in_month(stored.month, stored.year);
          end else if (stored.year > YEAR_MIN) begin
            stored.year = stored.year - 1'b1;
            stored.month = MONTH_DEC;
            stored.day = DAYS_31;
          end else begin
            res.ok = 1'b0;
          end
        end
        FUNC_CMP: begin
          compares++;
          res.order = order_of(stored.year, r.date.year);
          if (res.order == ORD_EQUAL) res.order = order_of(stored.month, r.date.month);
          if (res.order == ORD_EQUAL) res.order = order_of(stored.day, r.date.day);
        end
        FUNC_CENT: begin
          compares++;
          res.order = order_of(century_of(stored.year), century_of(r.date.year));
        end
        default: res.ok = 1'b0;
      endcase
      if (!res.ok) refused++;
      res.date = stored;
      pending.push_back(res);
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t ERROR %s", $time, msg);
    endtask

    task check_result(input rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %0d/%0d/%0d ok=%0d order=%0d with no request waiting",
                         got.date.month, got.date.day, got.date.year, got.ok, got.order));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.date.month !== want.date.month || got.date.day !== want.date.day ||
          got.date.year !== want.date.year || got.ok !== want.ok ||
          got.order !== want.order) begin
        report($sformatf("result %0d: got %0d/%0d/%0d ok=%0d order=%0d, want %0d/%0d/%0d ok=%0d order=%0d",
                         checked, got.date.month, got.date.day, got.date.year, got.ok,
                         got.order, want.date.month, want.date.day, want.date.year,
                         want.ok, want.order));
      end
    endtask
  endclass

  date_scoreboard sb = new();

  // both handshakes are sampled at the falling edge before the rising edge that completes them
  always @(negedge clk) begin : monitor
    req_t seen_req;
    rsp_t seen_rsp;
    if (rst_n) begin
      if (in_req.valid && in_req.ready) begin
        seen_req.func = in_req.func;
        seen_req.date.month = in_req.month_in;
        seen_req.date.day = in_req.day_in;
        seen_req.date.year = in_req.year_in;
        sb.note_request(seen_req);
      end
      if (out_rsp.valid && out_rsp.ready) begin
        seen_rsp.date.month = out_rsp.cur_month;
        seen_rsp.date.day = out_rsp.cur_day;
        seen_rsp.date.year = out_rsp.cur_year;
        seen_rsp.ok = out_rsp.ok;
        seen_rsp.order = out_rsp.order;
        sb.check_result(seen_rsp);
      end
    end
  end

  initial begin : receiver
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if (!rst_n || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, sb.pending.size());
    $display("DONE: errors detected");
    $finish;
  end

  // called in the step of a rising edge; returns in the step of the accepting edge
  task automatic send_req(input logic [FUNC_W-1:0] f, input logic [MONTH_W-1:0] m,
                          input logic [DAY_W-1:0] d, input logic [YEAR_W-1:0] y);
    bit rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.func <= f;
    in_req.month_in <= m;
    in_req.day_in <= d;
    in_req.year_in <= y;
    rdy = 1'b0;
    while (!rdy) begin
      @(negedge clk);
      rdy = in_req.ready;
      @(posedge clk);
    end
    sent++;
  endtask

  function automatic logic [YEAR_W-1:0] pick_year();
    case ($urandom_range(15))
      0: return YEAR_MIN;
      1: return YEAR_W'(4);
      2: return YEAR_W'(100);
      3: return YEAR_W'(400);
      4: return YEAR_W'(1900);
      5: return RESET_YEAR;
      6: return YEAR_W'(2100);
      7: return YEAR_MAX;
      8: return YEAR_W'(4 * $urandom_range(1, 2499));
      9: return YEAR_W'(100 * $urandom_range(1, 99));
      default: return YEAR_W'($urandom_range(1, 9999));
    endcase
  endfunction

  task automatic send_valid_load();
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0] d, len;
    logic [YEAR_W-1:0] y;
    y = pick_year();
    m = MONTH_W'($urandom_range(1, 12));
    len = days_in_month(m, y);
    case ($urandom_range(3))
      0: d = len;
      1: d = DAY_FIRST;
      2: d = len - 1'b1;
      default: d = DAY_W'($urandom_range(1, len));
    endcase
    send_req(FUNC_LOAD, m, d, y);
  endtask

  // a well-formed date with one field pushed out of range
  task automatic send_bad_load();
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0] d, len;
    logic [YEAR_W-1:0] y;
    y = pick_year();
    m = MONTH_W'($urandom_range(1, 12));
    len = days_in_month(m, y);
    d = DAY_W'($urandom_range(1, len));
    case ($urandom_range(5))
      0: d = '0;
      1: d = (len < DAYS_31) ? DAY_W'($urandom_range(len + 1, 31)) : '0;
      2: m = '0;
      3: m = MONTH_W'($urandom_range(13, 15));
      4: y = '0;
      default: y = YEAR_W'($urandom_range(10000, 16383));
    endcase
    send_req(FUNC_LOAD, m, d, y);
  endtask

  task automatic send_steps(input logic [FUNC_W-1:0] f, input int unsigned n);
    repeat (n) send_req(f, MONTH_W'($urandom), DAY_W'($urandom), YEAR_W'($urandom));
  endtask

  task automatic send_compare();
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0] d;
    logic [YEAR_W-1:0] y;
    m = sb.stored.month;
    d = sb.stored.day;
    y = sb.stored.year;
    case ($urandom_range(4))
      0: ;
      1: y = y + YEAR_W'($urandom_range(2)) - YEAR_W'(1);
      2: m = m + MONTH_W'($urandom_range(2)) - MONTH_W'(1);
      3: d = d + DAY_W'($urandom_range(2)) - DAY_W'(1);
      default: begin
        m = MONTH_W'($urandom);
        d = DAY_W'($urandom);
        y = YEAR_W'($urandom);
      end
    endcase
    send_req(FUNC_CMP, m, d, y);
  endtask

  task automatic send_century();
    logic [YEAR_W-1:0] y;
    y = sb.stored.year;
    case ($urandom_range(4))
      0: ;
      1: y = y + YEAR_W'($urandom_range(202)) - YEAR_W'(101);
      2: y = YEAR_W'(100 * $urandom_range(0, 163) + $urandom_range(2)) - YEAR_W'(1);
      3: y = '0;
      default: y = YEAR_W'($urandom);
    endcase
    send_req(FUNC_CENT, MONTH_W'($urandom), DAY_W'($urandom), y);
  endtask

  task automatic random_scenario();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 18) begin
      send_valid_load();
      if ($urandom_range(1)) send_steps($urandom_range(1) ? FUNC_NEXT : FUNC_PREV,
                                        $urandom_range(1, 4));
    end else if (pick < 24) begin
      send_bad_load();
    end else if (pick < 27) begin
      send_req(FUNC_LOAD, MONTH_W'($urandom), DAY_W'($urandom), YEAR_W'($urandom));
    end else if (pick < 30) begin
      // walk into the ends of the year range
      if ($urandom_range(1)) begin
        send_req(FUNC_LOAD, MONTH_DEC, $urandom_range(1) ? DAYS_31 : DAYS_30, YEAR_MAX);
        send_steps(FUNC_NEXT, $urandom_range(1, 3));
      end else begin
        send_req(FUNC_LOAD, MONTH_JAN, DAY_W'($urandom_range(1, 2)), YEAR_MIN);
        send_steps(FUNC_PREV, $urandom_range(1, 3));
      end
    end else if (pick < 56) begin
      send_steps(FUNC_NEXT, $urandom_range(1, 8));
    end else if (pick < 76) begin
      send_steps(FUNC_PREV, $urandom_range(1, 8));
    end else if (pick < 86) begin
      send_compare();
    end else if (pick < 95) begin
      send_century();
    end else if (pick < 98) begin
      send_req(FUNC_W'($urandom_range(FUNC_UNDEF_LO, FUNC_UNDEF_HI)), MONTH_W'($urandom),
               DAY_W'($urandom), YEAR_W'($urandom));
    end else begin
      send_req(FUNC_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom), YEAR_W'($urandom));
    end
  endtask

  task automatic run_directed();
    send_req(FUNC_CMP, MONTH_JAN, DAY_FIRST, RESET_YEAR);      // reset date, equal
    send_req(FUNC_CENT, MONTH_JAN, DAY_FIRST, YEAR_W'(2001));  // 2000 ends its century
    send_req(FUNC_CENT, '0, '0, '0);                          // year 0 is lowest century
    send_req(FUNC_CENT, MONTH_JAN, DAY_FIRST, RESET_YEAR);
    send_req(FUNC_LOAD, MONTH_FEB, DAYS_29, YEAR_W'(1900));   // century, not leap
    send_req(FUNC_LOAD, MONTH_FEB, DAYS_29, RESET_YEAR);      // divisible by 400
    send_req(FUNC_NEXT, '0, '0, '0);
    send_req(FUNC_PREV, '1, '1, '1);
    send_req(FUNC_LOAD, MONTH_FEB, DAYS_29, YEAR_W'(2023));
    send_req(FUNC_LOAD, MONTH_APR, DAYS_31, YEAR_W'(2021));
    send_req(FUNC_LOAD, '0, '0, '0);
    send_req(FUNC_LOAD, '1, '1, '1);
    send_req(FUNC_LOAD, MONTH_DEC, DAYS_31, YEAR_MAX);
    send_req(FUNC_NEXT, '0, '0, '0);                          // refused at the top
    send_req(FUNC_CMP, '1, '1, '1);                           // raw operand, not validated
    send_req(FUNC_PREV, '0, '0, '0);
    send_req(FUNC_LOAD, MONTH_JAN, DAY_FIRST, YEAR_MIN);
    send_req(FUNC_PREV, '0, '0, '0);                          // refused at the bottom
    send_req(FUNC_CMP, '0, '0, '0);
    send_req(FUNC_LOAD, MONTH_JAN, DAY_FIRST, YEAR_W'(2023));
    send_req(FUNC_PREV, '0, '0, '0);                          // back across the year end
    send_req(FUNC_NEXT, '0, '0, '0);
    for (logic [FUNC_W:0] f = (FUNC_W+1)'(FUNC_UNDEF_LO);
         f <= (FUNC_W+1)'(FUNC_UNDEF_HI); f++)
      send_req(f[FUNC_W-1:0], '1, '1, '1);
    send_req(FUNC_CENT, '0, '0, YEAR_W'(100));
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    int phase;
    rst_n <= 1'b0;
    in_req.valid <= 1'b0;
    in_req.func <= FUNC_LOAD;
    in_req.month_in <= '0;
    in_req.day_in <= '0;
    in_req.year_in <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      send_idle_pct = SEND_IDLE_PCT[phase];
      stall_pct = STALL_PCT[phase];
      phase_end = sent + RANDOM_PER_PHASE;
      while (sent < phase_end) random_scenario();
    end
    in_req.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests under %0d idle/stall mixes: %0d refused, %0d compares",
             sent, NUM_PHASES, sb.refused, sb.compares);
    $display("checked %0d results, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
